/* rtl/core/iat_pkg.sv */
// ----------------------------------------------------------------------------
// iat_pkg: shared types and codes of the interval attribute table
// Entry layout, cell commands, neighbor links, request and status codes.
// ----------------------------------------------------------------------------
package iat_pkg;

	// request codes
	localparam logic [1:0] RT_SPLIT = 2'd0;
	localparam logic [1:0] RT_SET   = 2'd1;
	localparam logic [1:0] RT_MERGE = 2'd2;
	localparam logic [1:0] RT_BAD   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISALIGN = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// buffer size after reset
	localparam logic [31:0] BUF_RESET = 32'd65536;

	// a listing reports at most this many intervals
	localparam int OUT_MAX = 32;
	localparam int KW      = $clog2(OUT_MAX);

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
		logic [63:0] acc;
		logic [63:0] stg;
		logic [7:0]  fam;
	} entry_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INIT,
		OP_CUT,
		OP_SET,
		OP_MERGE,
		OP_ROT
	} cell_op_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_op_t    op;
		logic [31:0] pos_a;
		logic [31:0] pos_b;
		logic        sel_b;
		logic [31:0] init_len;
		logic [63:0] acc;
		logic [63:0] stg;
		logic [7:0]  fam;
	} cell_ctl_t;

	// what a cell hands to its neighbors
	typedef struct packed {
		entry_t      e;
		logic        valid;
		logic [31:0] stop;
		logic        cont;
		logic        after;
		logic        pre;
		logic        first;
	} nbr_t;

	// per-cell match flags gathered by the controller
	typedef struct packed {
		logic start_hit;
		logic end_hit;
		logic in_rng;
		logic cont_a;
		logic cont_b;
	} cell_hit_t;

endpackage

/* rtl/core/iat_if.sv */
// ----------------------------------------------------------------------------
// iat_if: channel interfaces of the interval attribute table
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface iat_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] range_start;
	logic [31:0] range_length;
	logic [63:0] access_bits;
	logic [63:0] stage_bits;
	logic [7:0]  owner_family;

	modport source (output valid, req_type, range_start, range_length, access_bits,
		stage_bits, owner_family, input ready);
	modport sink (input valid, req_type, range_start, range_length, access_bits,
		stage_bits, owner_family, output ready);
endinterface

interface iat_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] entry_start;
	logic [31:0] entry_length;
	logic [63:0] entry_access;
	logic [63:0] entry_stages;
	logic [7:0]  entry_family;
	logic [1:0]  status;
	logic        last_of_run;

	modport source (output valid, entry_start, entry_length, entry_access, entry_stages,
		entry_family, status, last_of_run, input ready);
	modport sink (input valid, entry_start, entry_length, entry_access, entry_stages,
		entry_family, status, last_of_run, output ready);
endinterface

interface iat_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] buffer_size;

	modport source (output valid, buffer_size, input ready);
	modport sink (input valid, buffer_size, output ready);
endinterface

/* rtl/core/iat_cell.sv */
// ----------------------------------------------------------------------------
// iat_cell: one slot of the interval table
// Holds one interval and updates it from itself and its two neighbors:
// init, cut, attribute set, merge step and rotation toward the head.
// ----------------------------------------------------------------------------
module iat_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                is_head,
	input  iat_pkg::cell_ctl_t  ctl,
	input  iat_pkg::nbr_t       left_nb,
	input  iat_pkg::nbr_t       right_nb,
	output iat_pkg::nbr_t       nb_out,
	output iat_pkg::cell_hit_t  hit
);
	import iat_pkg::*;

	entry_t      e_q;
	logic        v_q;
	logic [31:0] e_end;
	logic [31:0] pos;
	logic        cont_a, cont_b, after_a, after_b, eq_left;

	// local compares against the broadcast positions
	always_comb begin
		e_end   = e_q.start + e_q.len;
		pos     = ctl.sel_b ? ctl.pos_b : ctl.pos_a;
		cont_a  = v_q && (e_q.start < ctl.pos_a) && (ctl.pos_a < e_end);
		cont_b  = v_q && (e_q.start < ctl.pos_b) && (ctl.pos_b < e_end);
		after_a = v_q && (e_q.start > ctl.pos_a);
		after_b = v_q && (e_q.start > ctl.pos_b);
		eq_left = v_q && left_nb.valid && (e_q.acc == left_nb.e.acc) &&
			(e_q.stg == left_nb.e.stg) && (e_q.fam == left_nb.e.fam);
	end

	// neighbor link; pre/first form the first-equal-pair chain
	always_comb begin
		nb_out.e     = e_q;
		nb_out.valid = v_q;
		nb_out.stop  = e_end;
		nb_out.cont  = ctl.sel_b ? cont_b : cont_a;
		nb_out.after = ctl.sel_b ? after_b : after_a;
		nb_out.pre   = left_nb.pre | eq_left;
		nb_out.first = eq_left & ~left_nb.pre;
		hit.start_hit = v_q && (e_q.start == ctl.pos_a);
		hit.end_hit   = v_q && (e_end == ctl.pos_b);
		hit.in_rng    = v_q && (e_q.start >= ctl.pos_a) && (e_end <= ctl.pos_b);
		hit.cont_a    = cont_a;
		hit.cont_b    = cont_b;
	end

	// slot update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= is_head;
			e_q <= '{start: 32'd0, len: (is_head ? BUF_RESET : 32'd0),
				acc: 64'd0, stg: 64'd0, fam: 8'd0};
		end else begin
			unique case (ctl.op)
				OP_HOLD: begin
				end
				OP_INIT: begin
					v_q <= is_head;
					e_q <= '{start: 32'd0, len: (is_head ? ctl.init_len : 32'd0),
						acc: 64'd0, stg: 64'd0, fam: 8'd0};
				end
				OP_CUT: begin
					if (nb_out.cont) begin
						e_q.len <= pos - e_q.start;
					end else if (left_nb.cont) begin
						e_q.start <= pos;
						e_q.len   <= left_nb.stop - pos;
						e_q.acc   <= left_nb.e.acc;
						e_q.stg   <= left_nb.e.stg;
						e_q.fam   <= left_nb.e.fam;
						v_q       <= 1'b1;
					end else if (left_nb.valid && left_nb.after) begin
						e_q <= left_nb.e;
						v_q <= 1'b1;
					end
				end
				OP_SET: begin
					if (hit.in_rng) begin
						e_q.acc <= ctl.acc;
						e_q.stg <= ctl.stg;
						e_q.fam <= ctl.fam;
					end
				end
				OP_MERGE: begin
					if (right_nb.first) begin
						e_q.len <= e_q.len + right_nb.e.len;
					end else if (nb_out.pre) begin
						e_q <= right_nb.e;
						v_q <= right_nb.valid;
					end
				end
				OP_ROT: begin
					e_q <= right_nb.e;
					v_q <= right_nb.valid;
				end
			endcase
		end
	end

endmodule

/* rtl/core/interval_attribute_table_unit.sv */
// ----------------------------------------------------------------------------
// interval_attribute_table_unit: ordered interval table with attributes
// A row of MAX_RANGES cells holds the intervals; a controller cuts, sets,
// merges and lists them through broadcast commands and neighbor links.
// ----------------------------------------------------------------------------
// Set and error: evaluate, then load the result.
// Coalesce: evaluate, one merge step per merged pair (at most MAX_RANGES-1), then the result.
// Split: evaluate, one cut per split point (0..2), then a full ring rotation of
//   MAX_RANGES steps emits the in-range intervals, one per cycle while not stalled.
// One request at a time; result register frees the input side early.
// Reset (and any buffer_size write) leaves one interval [0, size), zero attributes.
module interval_attribute_table_unit #(
	parameter int MAX_RANGES = 32
) (
	input logic        clk,
	input logic        arst_n,
	iat_cfg_if.sink    cfg,
	iat_req_if.sink    req,
	iat_rsp_if.source  rsp
);
	import iat_pkg::*;

	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int RW = $clog2(MAX_RANGES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CUTLO,
		S_CUTHI,
		S_MERGE,
		S_LIST,
		S_RESP
	} state_t;

	state_t          state_q;
	logic [1:0]      type_q;
	logic [31:0]     start_q;
	logic [31:0]     len_q;
	logic [32:0]     end_q;
	logic [63:0]     acc_q;
	logic [63:0]     stg_q;
	logic [7:0]      fam_q;
	logic [31:0]     buf_q;
	logic [CW-1:0]   count_q;
	logic [1:0]      status_q;
	logic            hi_q;
	logic [RW-1:0]   rot_q;
	logic [KW-1:0]   k_q;
	logic            done_q;
	logic            rsp_valid_q;
	entry_t          out_e_q;
	logic [1:0]      out_status_q;
	logic            out_last_q;

	cell_ctl_t       ctl;
	nbr_t            nb     [MAX_RANGES];
	nbr_t            left_in  [MAX_RANGES];
	nbr_t            right_in [MAX_RANGES];
	cell_hit_t       hit    [MAX_RANGES];
	nbr_t            tail;

	logic            lo, hi, sh, eh, any_merge, err_rng, aligned;
	logic [CW:0]     need;
	logic            out_free, head_emit, head_last, list_adv, cfg_fire, req_fire;
	logic            out_load;

	assign cfg_fire  = cfg.valid && cfg.ready;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	// cell row
	for (genvar c = 0; c < MAX_RANGES; c++) begin : g_cell
		if (c == 0) begin : g_l
			assign left_in[c] = '0;
		end else begin : g_l
			assign left_in[c] = nb[c-1];
		end
		if (c == MAX_RANGES - 1) begin : g_r
			assign right_in[c] = tail;
		end else begin : g_r
			assign right_in[c] = nb[c+1];
		end
		iat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.is_head (c == 0),
			.ctl     (ctl),
			.left_nb (left_in[c]),
			.right_nb(right_in[c]),
			.nb_out  (nb[c]),
			.hit     (hit[c])
		);
	end

	// ring closure: head wraps to tail only while rotating
	always_comb begin
		tail       = '0;
		tail.e     = nb[0].e;
		tail.valid = (ctl.op == OP_ROT) && nb[0].valid;
	end

	// gather match flags from the row
	always_comb begin
		lo = 1'b0;
		hi = 1'b0;
		sh = 1'b0;
		eh = 1'b0;
		for (int c = 0; c < MAX_RANGES; c++) begin
			lo = lo | hit[c].cont_a;
			hi = hi | hit[c].cont_b;
			sh = sh | hit[c].start_hit;
			eh = eh | hit[c].end_hit;
		end
		any_merge = nb[MAX_RANGES-1].pre;
		err_rng   = (len_q == 32'd0) || (end_q > {1'b0, buf_q});
		aligned   = sh && eh;
		need      = {1'b0, count_q} + (CW+1)'(lo) + (CW+1)'(hi);
		out_free  = !rsp_valid_q || rsp.ready;
		head_emit = (state_q == S_LIST) && nb[0].valid && hit[0].in_rng && !done_q;
		head_last = (nb[0].stop == end_q[31:0]) || (k_q == KW'(OUT_MAX - 1));
		list_adv  = (state_q == S_LIST) && (!head_emit || out_free);
		out_load  = out_free && (head_emit || (state_q == S_RESP));
	end

	// command to the row
	always_comb begin
		ctl          = '0;
		ctl.pos_a    = start_q;
		ctl.pos_b    = end_q[31:0];
		ctl.sel_b    = (state_q == S_CUTHI);
		ctl.init_len = cfg.buffer_size;
		ctl.acc      = acc_q;
		ctl.stg      = stg_q;
		ctl.fam      = fam_q;
		ctl.op       = OP_HOLD;
		if (cfg_fire) begin
			ctl.op = OP_INIT;
		end else begin
			unique case (state_q)
				S_EVAL:  ctl.op = (type_q == RT_SET && !err_rng && aligned) ? OP_SET : OP_HOLD;
				S_CUTLO: ctl.op = OP_CUT;
				S_CUTHI: ctl.op = OP_CUT;
				S_MERGE: ctl.op = any_merge ? OP_MERGE : OP_HOLD;
				S_LIST:  ctl.op = list_adv ? OP_ROT : OP_HOLD;
				S_IDLE:  ctl.op = OP_HOLD;
				S_RESP:  ctl.op = OP_HOLD;
			endcase
		end
	end

	// controller and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			buf_q       <= BUF_RESET;
			count_q     <= CW'(1);
			status_q    <= ST_OK;
			hi_q        <= 1'b0;
			rot_q       <= '0;
			k_q         <= '0;
			done_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// result valid: load wins over a drain
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				buf_q <= cfg.buffer_size;
			end
			// interval count follows the row commands
			if (cfg_fire) begin
				count_q <= CW'(1);
			end else if (state_q == S_CUTLO || state_q == S_CUTHI) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_MERGE && any_merge) begin
				count_q <= count_q - CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						type_q  <= req.req_type;
						start_q <= req.range_start;
						len_q   <= req.range_length;
						end_q   <= {1'b0, req.range_start} + {1'b0, req.range_length};
						acc_q   <= req.access_bits;
						stg_q   <= req.stage_bits;
						fam_q   <= req.owner_family;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					rot_q  <= '0;
					k_q    <= '0;
					done_q <= 1'b0;
					if (type_q == RT_BAD) begin
						status_q <= ST_RANGE;
						state_q  <= S_RESP;
					end else if (type_q == RT_MERGE) begin
						state_q <= S_MERGE;
					end else if (err_rng) begin
						status_q <= ST_RANGE;
						state_q  <= S_RESP;
					end else if (type_q == RT_SET) begin
						status_q <= aligned ? ST_OK : ST_MISALIGN;
						state_q  <= S_RESP;
					end else if (need > (CW+1)'(MAX_RANGES)) begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end else begin
						hi_q    <= hi;
						state_q <= lo ? S_CUTLO : (hi ? S_CUTHI : S_LIST);
					end
				end
				S_CUTLO: begin
					state_q <= hi_q ? S_CUTHI : S_LIST;
				end
				S_CUTHI: begin
					state_q <= S_LIST;
				end
				S_MERGE: begin
					if (!any_merge) begin
						status_q <= ST_OK;
						state_q  <= S_RESP;
					end
				end
				S_LIST: begin
					if (head_emit && out_free) begin
						out_e_q      <= nb[0].e;
						out_status_q <= ST_OK;
						out_last_q   <= head_last;
						k_q          <= k_q + KW'(1);
						done_q       <= done_q | head_last;
					end
					if (list_adv) begin
						rot_q <= rot_q + RW'(1);
						if (rot_q == RW'(MAX_RANGES - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_e_q      <= '0;
						out_status_q <= status_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.entry_start  = out_e_q.start;
	assign rsp.entry_length = out_e_q.len;
	assign rsp.entry_access = out_e_q.acc;
	assign rsp.entry_stages = out_e_q.stg;
	assign rsp.entry_family = out_e_q.fam;
	assign rsp.status       = out_status_q;
	assign rsp.last_of_run  = out_last_q;

endmodule

/* rtl/core/iat_checker.sv */
// ----------------------------------------------------------------------------
// iat_checker: port-level checks of the interval attribute table
// Watches the request and result channels and flags broken behavior.
// ----------------------------------------------------------------------------
module iat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_start,
	input logic [31:0] rsp_length,
	input logic [1:0]  rsp_status,
	input logic        rsp_last
);
	import iat_pkg::*;

	// a stalled result holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start) &&
		$stable(rsp_length) && $stable(rsp_status) && $stable(rsp_last))
		else $error("result changed while stalled");

	// one request at a time: input side closes after a transaction
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// an error result ends the run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_last)
		else $error("error result without last marker");

	// an error result carries no interval
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_start == 32'd0 && rsp_length == 32'd0)
		else $error("error result carries interval data");

endmodule

bind interval_attribute_table_unit iat_checker u_iat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_start (rsp.entry_start),
	.rsp_length(rsp.entry_length),
	.rsp_status(rsp.status),
	.rsp_last  (rsp.last_of_run)
);
